>>> hdl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the control-line deframer and status decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int STORE_DEPTH = 7;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [15:0] HDR_WORD = 16'h1610;
    localparam logic [7:0]  DLE      = 8'h10;
    localparam logic [7:0]  STX      = 8'h02;
    localparam logic [7:0]  ETX      = 8'h03;

    localparam logic [7:0] CODE_STATUS = 8'hF8;
    localparam logic [7:0] CODE_MODE   = 8'hF4;
    localparam logic [7:0] CODE_CHAN   = 8'hFE;

    localparam logic [CNT_W-1:0] LEN_STATUS = CNT_W'(9);
    localparam logic [CNT_W-1:0] LEN_SHORT  = CNT_W'(3);

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_MODE   = 2'd1;
    localparam logic [1:0] KIND_CHAN   = 2'd2;

    localparam logic [24:0] FREQ_BASE = 25'd4000000;
    localparam logic [24:0] FREQ_STEP = 25'd250;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BODY,
        PH_ESC,
        PH_TRAIL1,
        PH_TRAIL2
    } phase_t;

    typedef struct packed {
        logic                            done;
        logic                            in_trail2;
        logic                            overflow;
        logic [CNT_W-1:0]                count;
        logic [STORE_DEPTH-1:0][7:0]     payload;
    } frame_t;

endpackage

`default_nettype wire

>>> hdl/dds_deframe.sv
// ----------------------------------------------------------------------------
// dds_deframe
// Header hunt, body unstuffing and trailer skip for the control-line frames.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_deframe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    rx_byte,
    output dds_pkg::frame_t    frame
);
    import dds_pkg::*;

    phase_t                      phase_reg, phase_next;
    logic [15:0]                 window_reg, window_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [STORE_DEPTH-1:0][7:0] payload_reg;
    logic                        store_en;
    logic [7:0]                  store_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        store_en    = 1'b0;
        store_byte  = rx_byte;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_BODY:
                begin
                    if (rx_byte == DLE)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        store_en = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    if (rx_byte == DLE)
                    begin
                        store_en   = 1'b1;
                        store_byte = DLE;
                        phase_next = PH_BODY;
                    end
                    else if (rx_byte == ETX)
                    begin
                        phase_next = PH_TRAIL1;
                    end
                    else
                    begin
                        phase_next  = PH_HUNT;
                        window_next = {8'h00, rx_byte};
                    end
                end
                PH_TRAIL1:
                begin
                    phase_next = PH_TRAIL2;
                end
                PH_TRAIL2:
                begin
                    phase_next  = PH_HUNT;
                    window_next = 16'h0000;
                end
                default:
                begin
                    if (window_reg == HDR_WORD && rx_byte == STX)
                    begin
                        phase_next  = PH_BODY;
                        window_next = 16'h0000;
                        count_next  = '0;
                        ovf_next    = 1'b0;
                    end
                    else
                    begin
                        phase_next  = PH_HUNT;
                        window_next = {window_reg[7:0], rx_byte};
                    end
                end
            endcase
            if (store_en)
            begin
                if (count_reg < CNT_W'(MAX_PAYLOAD))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= 16'h0000;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en && count_reg < CNT_W'(STORE_DEPTH))
        begin
            payload_reg[count_reg[IDX_W-1:0]] <= store_byte;
        end
    end

    assign frame.done      = byte_valid && phase_reg == PH_TRAIL2;
    assign frame.in_trail2 = phase_reg == PH_TRAIL2;
    assign frame.overflow  = ovf_reg;
    assign frame.count     = count_reg;
    assign frame.payload   = payload_reg;

endmodule

`default_nettype wire

>>> hdl/dds_status.sv
// ----------------------------------------------------------------------------
// dds_status
// Payload decode, radio state registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_status (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  dds_pkg::frame_t    frame,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         report_kind,
    output logic [7:0]         work_mode,
    output logic [7:0]         channel_number,
    output logic [24:0]        tx_freq_100hz,
    output logic [24:0]        rx_freq_100hz,
    output logic               link_up
);
    import dds_pkg::*;

    logic        good_status, good_mode, good_chan, load;
    logic        copies_agree, frame_ok;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  chan_reg, chan_next;
    logic [15:0] tx_raw_reg, tx_raw_next;
    logic [15:0] rx_raw_reg, rx_raw_next;
    logic        conn_reg;
    logic [1:0]  kind_next;
    logic [24:0] tx_prod, rx_prod;
    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  out_mode_reg, out_chan_reg;
    logic [24:0] tx_freq_reg, rx_freq_reg;

    assign frame_ok     = frame.done && !frame.overflow;
    assign copies_agree = frame.payload[1] == frame.payload[2];
    assign good_status  = frame_ok && frame.count == LEN_STATUS
                          && frame.payload[0] == CODE_STATUS;
    assign good_mode    = frame_ok && frame.count == LEN_SHORT && copies_agree
                          && frame.payload[0] == CODE_MODE;
    assign good_chan    = frame_ok && frame.count == LEN_SHORT && copies_agree
                          && frame.payload[0] == CODE_CHAN;
    assign load         = good_status || good_mode || good_chan;

    always_comb
    begin
        mode_next   = mode_reg;
        chan_next   = chan_reg;
        tx_raw_next = tx_raw_reg;
        rx_raw_next = rx_raw_reg;
        kind_next   = KIND_STATUS;
        if (good_status)
        begin
            mode_next   = frame.payload[1];
            tx_raw_next = {frame.payload[2], frame.payload[3]};
            rx_raw_next = {frame.payload[4], frame.payload[5]};
            chan_next   = frame.payload[6];
        end
        else if (good_mode)
        begin
            mode_next = frame.payload[1];
            kind_next = KIND_MODE;
        end
        else if (good_chan)
        begin
            chan_next = frame.payload[1];
            kind_next = KIND_CHAN;
        end
    end

    assign tx_prod    = 25'(tx_raw_next) * FREQ_STEP;
    assign rx_prod    = 25'(rx_raw_next) * FREQ_STEP;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 8'h00;
            chan_reg   <= 8'h00;
            tx_raw_reg <= 16'h0000;
            rx_raw_reg <= 16'h0000;
            conn_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                mode_reg   <= mode_next;
                chan_reg   <= chan_next;
                tx_raw_reg <= tx_raw_next;
                rx_raw_reg <= rx_raw_next;
                conn_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= kind_next;
            out_mode_reg <= mode_next;
            out_chan_reg <= chan_next;
            tx_freq_reg  <= tx_prod + FREQ_BASE;
            rx_freq_reg  <= rx_prod + FREQ_BASE;
        end
    end

    assign out_valid      = valid_reg;
    assign report_kind    = kind_reg;
    assign work_mode      = out_mode_reg;
    assign channel_number = out_chan_reg;
    assign tx_freq_100hz  = tx_freq_reg;
    assign rx_freq_100hz  = rx_freq_reg;
    assign link_up        = conn_reg;

endmodule

`default_nettype wire

>>> hdl/dle_deframer_radio_status_decoder.sv
// ----------------------------------------------------------------------------
// dle_deframer_radio_status_decoder
// Control-line frame deframer with radio status reply decoding.
// ----------------------------------------------------------------------------
// One byte is taken per cycle; the parser state machine handles every byte in
// the cycle of its transfer. A report is valid the cycle after the transfer of the
// second trailer byte. Input stalls only on a second trailer byte while a
// report still waits. Reset clears the parser and radio state; the payload
// byte registers are not reset.
`default_nettype none

module dle_deframer_radio_status_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] report_kind, [9:2] work_mode, [17:10] channel_number,
    // [42:18] tx_freq_100hz, [67:43] rx_freq_100hz, [68] link_up, [71:69] zero
    output logic [71:0]      m_axis_tdata
);
    import dds_pkg::*;

    frame_t      frame;
    logic        byte_valid;
    logic [1:0]  report_kind;
    logic [7:0]  work_mode;
    logic [7:0]  channel_number;
    logic [24:0] tx_freq_100hz;
    logic [24:0] rx_freq_100hz;
    logic        link_up;

    assign s_axis_tready = !(frame.in_trail2 && m_axis_tvalid);
    assign byte_valid    = s_axis_tvalid && s_axis_tready;

    dds_deframe u_deframe (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (s_axis_tdata),
        .frame      (frame)
    );

    dds_status u_status (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame          (frame),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .report_kind    (report_kind),
        .work_mode      (work_mode),
        .channel_number (channel_number),
        .tx_freq_100hz  (tx_freq_100hz),
        .rx_freq_100hz  (rx_freq_100hz),
        .link_up        (link_up)
    );

    assign m_axis_tdata = {3'b000, link_up, rx_freq_100hz, tx_freq_100hz,
                           channel_number, work_mode, report_kind};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with no report pending.");

    a_report_has_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[68])
        else $error("Report given while link is down.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("Illegal report kind.");

    a_report_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("Report appeared without an input transfer.");

endmodule

`default_nettype wire
